[rtl/pss_pkg.sv]
// Shared types and codes for the process slot scheduler.
`default_nettype none

package pss_pkg;

  typedef enum logic [2:0] {
    OP_CREATE = 3'd0,
    OP_RUN    = 3'd1,
    OP_SCHED  = 3'd2,
    OP_SLEEP  = 3'd3,
    OP_WAKE   = 3'd4,
    OP_KILL   = 3'd5,
    OP_YIELD  = 3'd6,
    OP_CANCEL = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_NONE = 2'd1,
    STAT_ERR  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    MODE_FREE    = 3'd0,
    MODE_IDLE    = 3'd1,
    MODE_READY   = 3'd2,
    MODE_CURRENT = 3'd3,
    MODE_SLEEP   = 3'd4
  } mode_e;

  typedef struct packed {
    op_e         op;
    logic [3:0]  slot;
    logic [31:0] wait_address;
  } req_t;

  typedef struct packed {
    status_e    status;
    logic [3:0] slot_out;
    logic [4:0] woken_count;
    logic       woken_by_cancel;
  } res_t;

endpackage

`default_nettype wire

[rtl/pss_in_if.sv]
// Request channel: operation words into the scheduler.
`default_nettype none

interface pss_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [3:0]  slot;
  logic [31:0] wait_address;

  modport source (output valid, op, slot, wait_address, input ready);
  modport sink   (input valid, op, slot, wait_address, output ready);
endinterface

`default_nettype wire

[rtl/pss_out_if.sv]
// Result channel: one status word per operation.
`default_nettype none

interface pss_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [3:0] slot_out;
  logic [4:0] woken_count;
  logic       woken_by_cancel;

  modport source (output valid, status, slot_out, woken_count, woken_by_cancel, input ready);
  modport sink   (input valid, status, slot_out, woken_count, woken_by_cancel, output ready);
endinterface

`default_nettype wire

[rtl/process_slot_scheduler.sv]
// Top level of the process slot scheduler: sequencer plus result register.
//
//  channel | dir | word
//  --------+-----+-------------------------------------------------------
//  in_i    | in  | op, slot, wait_address
//  out_o   | out | status, slot_out, woken_count, woken_by_cancel
//
// One word in, one word out, one operation at a time. Run and yield also pass
// through S_TAIL when the old ready tail is read and patched. Wakeup and cancel
// walk the sleep list through S_WALK; each sleeper moved is rewritten in S_HITW,
// then S_TAIL patches the old tail if the ready list is non-empty (one read port).
// Reset empties all lists at once; written bits make untouched slots read as free.
// The result register lets the next word start while a result waits.
`default_nettype none

module process_slot_scheduler #(
  parameter int SLOTS        = 16,
  parameter int ADDRESS_BITS = 32
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  pss_in_if.sink   in_i,
  pss_out_if.source out_o
);
  import pss_pkg::*;

  req_t req;
  res_t res, out_q;
  logic res_valid, res_ready, out_v_q;

  assign req.op           = op_e'(in_i.op);
  assign req.slot         = in_i.slot;
  assign req.wait_address = in_i.wait_address;

  pss_core #(.SLOTS(SLOTS), .ADDRESS_BITS(ADDRESS_BITS)) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_i.valid),
    .req_ready_o (in_i.ready),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // result register: refills in the cycle it is drained
  assign res_ready = !out_v_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) out_q <= res;
  end

  assign out_o.valid           = out_v_q;
  assign out_o.status          = out_q.status;
  assign out_o.slot_out        = out_q.slot_out;
  assign out_o.woken_count     = out_q.woken_count;
  assign out_o.woken_by_cancel = out_q.woken_by_cancel;

endmodule

`default_nettype wire

[rtl/pss_ram.sv]
// Generic simple dual-port RAM, one write and one registered read port.
`default_nettype none

module pss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic                                   re_i,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output      logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[rtl/pss_core.sv]
// Scheduler sequencer: list updates as read-modify-write on the slot tables.
`default_nettype none

module pss_core #(
  parameter int SLOTS        = 16,
  parameter int ADDRESS_BITS = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          req_valid_i,
  output      logic          req_ready_o,
  input  wire pss_pkg::req_t req_i,
  output      logic          res_valid_o,
  input  wire logic          res_ready_i,
  output      pss_pkg::res_t res_o
);
  import pss_pkg::*;

  localparam int SW   = $clog2(SLOTS);
  localparam int CNTW = $clog2(SLOTS + 1);
  localparam int AW   = (ADDRESS_BITS < 32) ? ADDRESS_BITS : 32;

  typedef struct packed {
    mode_e         mode;
    logic          cflag;
    logic          lv;
    logic [SW-1:0] link;
  } ent_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CHK, S_RUN, S_SCHED, S_WALK, S_HITW, S_TAIL, S_DONE
  } state_e;

  function automatic ent_t mk_ent(mode_e m, logic c, logic l, logic [SW-1:0] k);
    ent_t e;
    e.mode  = m;
    e.cflag = c;
    e.lv    = l;
    e.link  = k;
    return e;
  endfunction

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [AW-1:0] addr_q, addr_d;
  status_e status_q, status_d;
  logic [3:0] slot_o_q, slot_o_d;
  logic wbc_q, wbc_d;
  logic [CNTW-1:0] cnt_q, cnt_d, n_q, n_d, n_nx;

  logic [SW-1:0] ready_head_q, ready_head_d, ready_tail_q, ready_tail_d;
  logic [SW-1:0] idle_top_q, idle_top_d, sleep_head_q, sleep_head_d;
  logic [SW-1:0] run_slot_q, run_slot_d;
  logic ready_ne_q, ready_ne_d, idle_ne_q, idle_ne_d, sleep_ne_q, sleep_ne_d;
  logic run_v_q, run_v_d;

  // walk and append bookkeeping
  logic [SW-1:0] cur_q, cur_d, prev_q, prev_d, nxt_q, nxt_d, app_q, app_d;
  ent_t prev_ent_q, prev_ent_d;
  logic has_prev_q, has_prev_d, ok_q, ok_d, cw_q, cw_d;

  logic [SLOTS-1:0] wr_q, wr_d;
  logic rv_q;

  // table ports
  logic          c_we, a_we, re;
  logic [SW-1:0] c_waddr, raddr;
  ent_t          c_wdata, c_rdata, ent;
  logic [AW-1:0] a_rdata;

  logic          do_app, do_cont, cont_walk, by_slot, hit, in_range;
  logic [SW-1:0] app_slot;

  pss_ram #(.WIDTH($bits(ent_t)), .DEPTH(SLOTS)) u_ctrl_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (c_rdata)
  );

  pss_ram #(.WIDTH(AW), .DEPTH(SLOTS)) u_addr_ram (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (run_slot_q),
    .wdata_i (req_i.wait_address[AW-1:0]),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (a_rdata)
  );

  // never-written entries read as free
  assign ent      = rv_q ? c_rdata : '0;
  assign by_slot  = (op_q == OP_CANCEL);
  assign hit      = by_slot ? (cur_q == slot_q) : (a_rdata == addr_q);
  assign in_range = ({5'd0, req_i.slot} < 9'(SLOTS));
  assign n_nx     = n_q + 1'b1;

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);

  always_comb begin
    logic [8:0] cnt_w;
    cnt_w = 9'(cnt_q);
    res_o.status          = status_q;
    res_o.slot_out        = slot_o_q;
    res_o.woken_count     = (op_q != OP_WAKE) ? 5'd0 :
                            (cnt_w > 9'd31) ? 5'd31 : cnt_w[4:0];
    res_o.woken_by_cancel = wbc_q;
  end

  always_comb begin
    state_d = state_q;  op_d = op_q;  slot_d = slot_q;  addr_d = addr_q;
    status_d = status_q;  slot_o_d = slot_o_q;  wbc_d = wbc_q;
    cnt_d = cnt_q;  n_d = n_q;
    ready_head_d = ready_head_q;  ready_tail_d = ready_tail_q;
    idle_top_d = idle_top_q;  sleep_head_d = sleep_head_q;
    run_slot_d = run_slot_q;  ready_ne_d = ready_ne_q;  idle_ne_d = idle_ne_q;
    sleep_ne_d = sleep_ne_q;  run_v_d = run_v_q;
    cur_d = cur_q;  prev_d = prev_q;  nxt_d = nxt_q;  app_d = app_q;
    prev_ent_d = prev_ent_q;  has_prev_d = has_prev_q;  ok_d = ok_q;  cw_d = cw_q;
    wr_d = wr_q;
    c_we = 1'b0;  c_waddr = '0;  c_wdata = '0;  a_we = 1'b0;
    re = 1'b0;  raddr = '0;
    do_app = 1'b0;  app_slot = '0;  do_cont = 1'b0;  cont_walk = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          op_d     = req_i.op;
          slot_d   = SW'(req_i.slot);
          addr_d   = req_i.wait_address[AW-1:0];
          status_d = STAT_OK;
          slot_o_d = 4'd0;
          wbc_d    = 1'b0;
          cnt_d    = '0;
          n_d      = '0;
          has_prev_d = 1'b0;
          unique case (req_i.op)
            OP_CREATE, OP_KILL, OP_CANCEL: begin
              if (!in_range) begin
                status_d = STAT_ERR;
                state_d  = S_DONE;
              end else begin
                re      = 1'b1;
                raddr   = SW'(req_i.slot);
                state_d = S_CHK;
              end
            end
            OP_RUN: begin
              if (!idle_ne_q) begin
                status_d = STAT_NONE;
                state_d  = S_DONE;
              end else begin
                re      = 1'b1;
                raddr   = idle_top_q;
                state_d = S_RUN;
              end
            end
            OP_SCHED: begin
              if (run_v_q) begin
                status_d = STAT_ERR;
                state_d  = S_DONE;
              end else if (!ready_ne_q) begin
                status_d = STAT_NONE;
                state_d  = S_DONE;
              end else begin
                re      = 1'b1;
                raddr   = ready_head_q;
                state_d = S_SCHED;
              end
            end
            OP_SLEEP: begin
              state_d = S_DONE;
              if (!run_v_q) begin
                status_d = STAT_ERR;
              end else begin
                c_we         = 1'b1;
                a_we         = 1'b1;
                c_waddr      = run_slot_q;
                c_wdata      = mk_ent(MODE_SLEEP, 1'b0, sleep_ne_q, sleep_head_q);
                sleep_head_d = run_slot_q;
                sleep_ne_d   = 1'b1;
                run_v_d      = 1'b0;
              end
            end
            OP_WAKE: begin
              if (!sleep_ne_q) begin
                state_d = S_DONE;
              end else begin
                cur_d   = sleep_head_q;
                re      = 1'b1;
                raddr   = sleep_head_q;
                state_d = S_WALK;
              end
            end
            OP_YIELD: begin
              if (!run_v_q) begin
                status_d = STAT_ERR;
                state_d  = S_DONE;
              end else begin
                c_we     = 1'b1;
                c_waddr  = run_slot_q;
                c_wdata  = mk_ent(MODE_READY, 1'b0, 1'b0, '0);
                run_v_d  = 1'b0;
                do_app   = 1'b1;
                app_slot = run_slot_q;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end

      S_CHK: begin
        state_d = S_DONE;
        unique case (op_q)
          OP_CREATE, OP_KILL: begin
            if (ent.mode != ((op_q == OP_CREATE) ? MODE_FREE : MODE_CURRENT)) begin
              status_d = STAT_ERR;
            end else begin
              c_we       = 1'b1;
              c_waddr    = slot_q;
              c_wdata    = mk_ent(MODE_IDLE, 1'b0, idle_ne_q, idle_top_q);
              idle_top_d = slot_q;
              idle_ne_d  = 1'b1;
              if (op_q == OP_KILL) run_v_d = 1'b0;
            end
          end
          OP_CANCEL: begin
            status_d = STAT_NONE;
            if (ent.mode == MODE_SLEEP && sleep_ne_q) begin
              cur_d   = sleep_head_q;
              re      = 1'b1;
              raddr   = sleep_head_q;
              state_d = S_WALK;
            end
          end
          default: ;
        endcase
      end

      S_RUN: begin
        c_we       = 1'b1;
        c_waddr    = idle_top_q;
        c_wdata    = mk_ent(MODE_READY, 1'b0, 1'b0, ent.link);
        idle_top_d = ent.link;
        idle_ne_d  = ent.lv;
        slot_o_d   = 4'(idle_top_q);
        do_app     = 1'b1;
        app_slot   = idle_top_q;
      end

      S_SCHED: begin
        c_we         = 1'b1;
        c_waddr      = ready_head_q;
        c_wdata      = mk_ent(MODE_CURRENT, 1'b0, ent.lv, ent.link);
        ready_head_d = ent.link;
        ready_ne_d   = ent.lv;
        run_slot_d   = ready_head_q;
        run_v_d      = 1'b1;
        slot_o_d     = 4'(ready_head_q);
        wbc_d        = ent.cflag;
        state_d      = S_DONE;
      end

      S_WALK: begin
        n_d   = n_nx;
        nxt_d = ent.link;
        ok_d  = ent.lv;
        if (hit) begin
          // unlink: patch the predecessor or the list head
          if (has_prev_q) begin
            c_we            = 1'b1;
            c_waddr         = prev_q;
            c_wdata         = prev_ent_q;
            c_wdata.link    = ent.link;
            c_wdata.lv      = ent.lv;
            prev_ent_d.link = ent.link;
            prev_ent_d.lv   = ent.lv;
          end else begin
            sleep_head_d = ent.link;
            sleep_ne_d   = ent.lv;
          end
          cnt_d = cnt_q + 1'b1;
          if (by_slot) status_d = STAT_OK;
          state_d = S_HITW;
        end else begin
          prev_d     = cur_q;
          prev_ent_d = ent;
          has_prev_d = 1'b1;
          if (ent.lv && (9'(n_nx) < 9'(SLOTS))) begin
            cur_d = ent.link;
            re    = 1'b1;
            raddr = ent.link;
          end else begin
            state_d = S_DONE;
          end
        end
      end

      S_HITW: begin
        c_we      = 1'b1;
        c_waddr   = cur_q;
        c_wdata   = mk_ent(MODE_READY, by_slot, 1'b0, nxt_q);
        do_app    = 1'b1;
        app_slot  = cur_q;
        cont_walk = !by_slot;
      end

      S_TAIL: begin
        c_we         = 1'b1;
        c_waddr      = ready_tail_q;
        c_wdata      = ent;
        c_wdata.link = app_q;
        c_wdata.lv   = 1'b1;
        ready_tail_d = app_q;
        do_cont      = 1'b1;
        cont_walk    = cw_q;
      end

      S_DONE: begin
        if (res_ready_i) state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase

    // ready FIFO append; a non-empty FIFO needs the old tail read first
    if (do_app) begin
      if (ready_ne_q) begin
        re      = 1'b1;
        raddr   = ready_tail_q;
        app_d   = app_slot;
        cw_d    = cont_walk;
        state_d = S_TAIL;
      end else begin
        ready_head_d = app_slot;
        ready_tail_d = app_slot;
        ready_ne_d   = 1'b1;
        do_cont      = 1'b1;
      end
    end

    if (do_cont) begin
      if (cont_walk && ok_q && (9'(n_q) < 9'(SLOTS))) begin
        cur_d   = nxt_q;
        re      = 1'b1;
        raddr   = nxt_q;
        state_d = S_WALK;
      end else begin
        state_d = S_DONE;
      end
    end

    if (c_we) wr_d[c_waddr] = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ready_head_q <= '0;
      ready_tail_q <= '0;
      idle_top_q   <= '0;
      sleep_head_q <= '0;
      run_slot_q   <= '0;
      ready_ne_q   <= 1'b0;
      idle_ne_q    <= 1'b0;
      sleep_ne_q   <= 1'b0;
      run_v_q      <= 1'b0;
      wr_q         <= '0;
      rv_q         <= 1'b0;
    end else begin
      state_q      <= state_d;
      ready_head_q <= ready_head_d;
      ready_tail_q <= ready_tail_d;
      idle_top_q   <= idle_top_d;
      sleep_head_q <= sleep_head_d;
      run_slot_q   <= run_slot_d;
      ready_ne_q   <= ready_ne_d;
      idle_ne_q    <= idle_ne_d;
      sleep_ne_q   <= sleep_ne_d;
      run_v_q      <= run_v_d;
      wr_q         <= wr_d;
      if (re) rv_q <= wr_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    slot_q     <= slot_d;
    addr_q     <= addr_d;
    status_q   <= status_d;
    slot_o_q   <= slot_o_d;
    wbc_q      <= wbc_d;
    cnt_q      <= cnt_d;
    n_q        <= n_d;
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    nxt_q      <= nxt_d;
    app_q      <= app_d;
    prev_ent_q <= prev_ent_d;
    has_prev_q <= has_prev_d;
    ok_q       <= ok_d;
    cw_q       <= cw_d;
  end

endmodule

`default_nettype wire
